[rtl/core/sbfr_pkg.sv]
package sbfr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAYLOAD,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic open_frame;
    logic take_byte;
    logic check_sum;
    logic emit_byte;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_hit;
    logic cnt_last;
    logic sum_match;
    logic out_free;
  } status_t;

  localparam logic [7:0] START_RESET = 8'h9A;
  localparam int unsigned POS_W = 6;

endpackage

[rtl/core/sbfr_ctrl.sv]
module sbfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbfr_pkg::status_t status,
  output sbfr_pkg::cmd_t    cmd
);
  import sbfr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.start_hit) begin
          cmd.open_frame = 1'b1;
          state_next     = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (status.cnt_last) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // A bad checksum byte produces a result, so the output register must be free.
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.check_sum = 1'b1;
          state_next    = status.sum_match ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_byte = 1'b1;
          if (status.cnt_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/sbfr_dp.sv]
module sbfr_dp #(
  parameter int unsigned PAYLOAD_BYTES = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [7:0]                    cfg_data,
  input  logic [7:0]                    rx_byte,
  input  sbfr_pkg::cmd_t                cmd,
  output sbfr_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          frame_ok,
  output logic [7:0]                    payload_value,
  output logic [sbfr_pkg::POS_W-1:0]    payload_position,
  output logic                          last_of_run,
  output logic [31:0]                   good_frames,
  output logic [31:0]                   bad_frames
);
  import sbfr_pkg::*;

  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

  logic [7:0]       start_value;
  logic [7:0]       running_sum;
  logic [IDX_W-1:0] cnt;
  logic [31:0]      good_count;
  logic [31:0]      bad_count;
  logic [7:0]       payload_store [PAYLOAD_BYTES];
  logic             out_free;

  assign out_free         = !out_valid || out_ready;
  assign status.start_hit = (rx_byte == start_value);
  assign status.cnt_last  = (cnt == IDX_LAST);
  assign status.sum_match = (rx_byte == running_sum);
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_RESET;
    end else if (cfg_write) begin
      start_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      payload_store[cnt] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      cnt         <= '0;
      good_count  <= '0;
      bad_count   <= '0;
    end else begin
      if (cmd.open_frame) begin
        running_sum <= '0;
        cnt         <= '0;
      end
      if (cmd.take_byte) begin
        running_sum <= running_sum + rx_byte;
        cnt         <= status.cnt_last ? '0 : cnt + 1'b1;
      end
      if (cmd.check_sum) begin
        running_sum <= '0;
        cnt         <= '0;
        if (status.sum_match) begin
          good_count <= good_count + 32'd1;
        end else begin
          bad_count <= bad_count + 32'd1;
        end
      end
      if (cmd.emit_byte) begin
        cnt <= status.cnt_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.check_sum && !status.sum_match) || cmd.emit_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload fields of the output register; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.check_sum && !status.sum_match) begin
      frame_ok         <= 1'b0;
      payload_value    <= '0;
      payload_position <= '0;
      last_of_run      <= 1'b1;
      good_frames      <= good_count;
      bad_frames       <= bad_count + 32'd1;
    end else if (cmd.emit_byte) begin
      frame_ok         <= 1'b1;
      payload_value    <= payload_store[cnt];
      payload_position <= POS_W'(cnt);
      last_of_run      <= status.cnt_last;
      good_frames      <= good_count;
      bad_frames       <= bad_count;
    end
  end

endmodule

[rtl/core/start_byte_frame_receiver_checksum_top.sv]
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_data (start_value)
// in        in         in_valid/in_ready     rx_byte
// out       out        out_valid/out_ready   frame_ok, payload_value, payload_position,
//                                            last_of_run, good_frames, bad_frames
//
// A byte that opens or fills a frame produces no output.
// A good frame streams PAYLOAD_BYTES results from the payload store, one per cycle while the
// output is not stalled, and no byte is taken during that run.
// A checksum byte is taken only when the output register is free.
// Reset is synchronous and active high; the payload store needs no clearing.
// Output stalls hold the result in the output register and pause the payload run.
module start_byte_frame_receiver_checksum_top #(
  parameter int unsigned PAYLOAD_BYTES = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       frame_ok,
  output logic [7:0]                 payload_value,
  output logic [sbfr_pkg::POS_W-1:0] payload_position,
  output logic                       last_of_run,
  output logic [31:0]                good_frames,
  output logic [31:0]                bad_frames
);
  import sbfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sbfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbfr_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .rx_byte          (rx_byte),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_ok         (frame_ok),
    .payload_value    (payload_value),
    .payload_position (payload_position),
    .last_of_run      (last_of_run),
    .good_frames      (good_frames),
    .bad_frames       (bad_frames)
  );

endmodule

[sim/sbfr_scoreboard.sv]
`timescale 1ns / 1ps

module sbfr_scoreboard #(
  parameter int unsigned PAYLOAD_BYTES = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       frame_ok,
  input  logic [7:0]                 payload_value,
  input  logic [sbfr_pkg::POS_W-1:0] payload_position,
  input  logic                       last_of_run,
  input  logic [31:0]                good_frames,
  input  logic [31:0]                bad_frames,
  output int                         mismatches,
  output int                         outstanding
);
  import sbfr_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [7:0]       value;
    logic [POS_W-1:0] position;
    logic             last;
    logic [31:0]      good;
    logic [31:0]      bad;
  } frame_word_t;

  frame_word_t      pending_words[$];
  logic [7:0]       start_val;
  logic [7:0]       sum_acc;
  logic [POS_W-1:0] rx_pos;
  logic [7:0]       payload_mem[PAYLOAD_BYTES];
  logic [31:0]      good_tally;
  logic [31:0]      bad_tally;
  int               reported;

  // Advances the frame decoder by one received byte and queues whatever the frame produces.
  task automatic decode_rx_byte(input logic [7:0] b);
    frame_word_t w;
    if (rx_pos == 0) begin
      if (b == start_val) begin
        rx_pos = POS_W'(1);
        sum_acc = 8'h00;
      end
    end else if (rx_pos <= PAYLOAD_BYTES) begin
      payload_mem[rx_pos - 1'b1] = b;
      sum_acc = sum_acc + b;
      rx_pos = rx_pos + 1'b1;
    end else begin
      rx_pos = '0;
      if (b == sum_acc) begin
        good_tally = good_tally + 1;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
          w.ok = 1'b1;
          w.value = payload_mem[k];
          w.position = k[POS_W-1:0];
          w.last = (k == PAYLOAD_BYTES - 1);
          w.good = good_tally;
          w.bad = bad_tally;
          pending_words.push_back(w);
        end
      end else begin
        bad_tally = bad_tally + 1;
        w = '{1'b0, 8'h00, '0, 1'b1, good_tally, bad_tally};
        pending_words.push_back(w);
      end
      sum_acc = 8'h00;
    end
  endtask

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      start_val = START_RESET;
      sum_acc = 8'h00;
      rx_pos = '0;
      good_tally = '0;
      bad_tally = '0;
      pending_words.delete();
      mismatches = 0;
      reported = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{frame_ok, payload_value, payload_position, last_of_run, good_frames,
                bad_frames};
        if (pending_words.size() == 0) begin
          mismatches++;
          if (reported < 10)
            $display("unexpected frame result: ok=%0d value=%02h pos=%0d last=%0d",
                     got.ok, got.value, got.position, got.last);
          reported++;
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (reported < 10) begin
              $display("frame result mismatch: expected ok=%0d value=%02h pos=%0d last=%0d",
                       want.ok, want.value, want.position, want.last);
              $display("  good=%0d bad=%0d, got ok=%0d value=%02h pos=%0d last=%0d",
                       want.good, want.bad, got.ok, got.value, got.position, got.last);
              $display("  good=%0d bad=%0d", got.good, got.bad);
            end
            reported++;
          end
        end
      end
      // Writes only happen while no frame byte is in flight, so the order here is safe.
      if (cfg_valid && cfg_ready)
        start_val = cfg_data;
      if (in_valid && in_ready)
        decode_rx_byte(rx_byte);
    end
    outstanding = pending_words.size();
  end

endmodule

[sim/tb_start_byte_frame_receiver_checksum_top.sv]
`timescale 1ns / 1ps

module tb_start_byte_frame_receiver_checksum_top;
  import sbfr_pkg::*;

  localparam int unsigned PAYLOAD_BYTES = 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 100;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 frame_ok;
  logic [7:0]           payload_value;
  logic [POS_W-1:0]     payload_position;
  logic                 last_of_run;
  logic [31:0]          good_frames;
  logic [31:0]          bad_frames;
  int                   fail_total;
  int                   pending_results;

  int                   idle_pct;
  int                   stall_pct;
  int                   hold_len;
  int                   hold_serial;
  int                   frame_items;
  int                   cycle_count;
  logic [7:0]           frame_buf[PAYLOAD_BYTES];

  start_byte_frame_receiver_checksum_top #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_ok(frame_ok),
    .payload_value(payload_value),
    .payload_position(payload_position),
    .last_of_run(last_of_run),
    .good_frames(good_frames),
    .bad_frames(bad_frames)
  );

  sbfr_scoreboard #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_scoreboard (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_ok(frame_ok),
    .payload_value(payload_value),
    .payload_position(payload_position),
    .last_of_run(last_of_run),
    .good_frames(good_frames),
    .bad_frames(bad_frames),
    .mismatches(fail_total),
    .outstanding(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver side: random stalls, plus a long hold-off whenever hold_serial is bumped.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_serial) begin
        hold_seen = hold_serial;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_rx_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] sof, input bit corrupt);
    logic [7:0] sum;
    sum = 8'h00;
    offer_rx_byte(sof);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      offer_rx_byte(frame_buf[k]);
      sum = sum + frame_buf[k];
    end
    if (corrupt)
      sum = sum + 8'($urandom_range(255, 1));
    offer_rx_byte(sum);
    frame_items += PAYLOAD_BYTES + 2;
  endtask

  // Payload bytes lean toward the start value and the byte extremes.
  task automatic fill_random_payload(input logic [7:0] sof);
    int pick;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      pick = $urandom_range(9);
      case (pick)
        0: frame_buf[k] = sof;
        1: frame_buf[k] = 8'h00;
        2: frame_buf[k] = 8'hFF;
        default: frame_buf[k] = 8'($urandom_range(255));
      endcase
    end
  endtask

  // Waits for every queued result, then lets trailing frame bytes settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
    repeat (2 * PAYLOAD_BYTES + 8) @(negedge clk);
  endtask

  task automatic write_start_value(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] phase_start[5];
    int         phase_idle[5];
    int         phase_stall[5];
    int         noise_len;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_serial = 0;
    frame_items = 0;

    phase_start = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255)), START_RESET};
    phase_idle = '{0, 65, 0, 16, 0};
    phase_stall = '{0, 0, 65, 16, 0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bytes outside a frame that do not match the start value are dropped.
    offer_rx_byte(8'h00);
    offer_rx_byte(8'hFF);
    offer_rx_byte(START_RESET ^ 8'h01);
    // A good frame with both byte extremes and the start value as data, then a bad one.
    for (int k = 0; k < PAYLOAD_BYTES; k++)
      frame_buf[k] = 8'(k * 37 + 5);
    frame_buf[0] = 8'h00;
    frame_buf[1] = 8'hFF;
    frame_buf[2] = START_RESET;
    frame_buf[3] = START_RESET;
    send_frame(START_RESET, 1'b0);
    send_frame(START_RESET, 1'b1);
    drain_results();

    for (int p = 0; p < 5; p++) begin
      write_start_value(phase_start[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 2) begin
        hold_len = 400;
        hold_serial++;
      end
      frame_items = 0;
      while (frame_items < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          noise_len = $urandom_range(3, 1);
          repeat (noise_len) offer_rx_byte(8'($urandom_range(255)));
        end
        fill_random_payload(phase_start[p]);
        send_frame(phase_start[p], $urandom_range(3) == 0);
      end
      drain_results();
    end

    if (fail_total == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[start_byte_frame_receiver_checksum_top.f]
rtl/core/sbfr_pkg.sv
rtl/core/sbfr_ctrl.sv
rtl/core/sbfr_dp.sv
rtl/core/start_byte_frame_receiver_checksum_top.sv
sim/sbfr_scoreboard.sv
sim/tb_start_byte_frame_receiver_checksum_top.sv
